// ===== rtl/efi_pkg.sv =====
// Shared types and constants for the escape-time fractal iterator.
// Used by the intensity divider and the top level; no dependencies.
package efi_pkg;

    // Width of the intensity result and of the divider quotient.
    localparam int INTENSITY_WIDTH = 8;

    // Width of the configuration register index.
    localparam int CFG_INDEX_WIDTH = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_ITERATIONS = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_REAL     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_IMAG     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KNEE_COUNT     = 3'd3;

endpackage

// ===== rtl/escape_time_fractal_iterator.sv =====
// Escape-time fractal iterator: z = z*z + c on one shared multiplier.
// Depends on efi_pkg, efi_mul and efi_div.
//
// Usage: a point (c_real, c_imag), signed fixed point with COORD_WIDTH-4
// fraction bits, is taken as one beat on the input channel when in_valid and
// in_ready are both high. One intensity beat per point comes out on the
// output channel when out_valid and out_ready are both high.
// Each iteration runs on the shared multiplier through S_RR, S_II, S_RI and
// S_UPD: zr*zr, zi*zi, zr*zi, then the update of z. The squares of the new z
// serve as its escape test. The intensity of a point comes from the divider;
// a found cycle or a zero count skips the divider and gives zero.
// The block works on one point at a time; in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next point is accepted while that result waits; a second finished result
// waits in the sequencer until the receiver takes the first one.
// Reset clears the sequencer and output valid and loads the registers with
// max_iterations = 256, start = 0 and knee_count = 16. Configuration is
// written through cfg_we, cfg_index and cfg_data, by the user only while
// no point is in work (not enforced by the block); indexes above 3 are ignored.
module escape_time_fractal_iterator #(
    parameter int COORD_WIDTH = 32,
    parameter int ITER_WIDTH  = 16,
    localparam int CFG_WIDTH  = (COORD_WIDTH > ITER_WIDTH) ? COORD_WIDTH : ITER_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_WIDTH-1:0]         c_real,
    input  logic signed [COORD_WIDTH-1:0]         c_imag,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [efi_pkg::INTENSITY_WIDTH-1:0]   intensity,
    input  logic                                  cfg_we,
    input  logic [efi_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]                  cfg_data
);

    localparam int W     = COORD_WIDTH;
    localparam int PW    = 2 * COORD_WIDTH;
    localparam int FRAC  = COORD_WIDTH - 4;
    localparam int SW    = W + 6;
    localparam int QW    = efi_pkg::INTENSITY_WIDTH;
    localparam int NUM_W = ITER_WIDTH + 8;
    localparam int DEN_W = ITER_WIDTH + 1;
    localparam logic [PW-1:0] LIMIT = PW'(1) << (2 * FRAC + 2);
    localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RR,
        S_II,
        S_RI,
        S_UPD,
        S_DIV,
        S_DONE
    } state_t;

    // Clamp a wide sum to the coordinate range.
    function automatic logic signed [W-1:0] saturate(input logic [SW-1:0] v);
        if (v[SW-1:W-1] == {(SW-W+1){v[SW-1]}})
        begin
            return v[W-1:0];
        end
        else if (v[SW-1])
        begin
            return MIN_V;
        end
        else
        begin
            return MAX_V;
        end
    endfunction

    // Configuration registers.
    logic [ITER_WIDTH-1:0]  max_iter_reg;
    logic signed [W-1:0]    start_re_reg;
    logic signed [W-1:0]    start_im_reg;
    logic [ITER_WIDTH-1:0]  knee_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= ITER_WIDTH'(256);
            start_re_reg <= '0;
            start_im_reg <= '0;
            knee_reg     <= ITER_WIDTH'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                efi_pkg::REG_MAX_ITERATIONS: max_iter_reg <= cfg_data[ITER_WIDTH-1:0];
                efi_pkg::REG_START_REAL:     start_re_reg <= cfg_data[W-1:0];
                efi_pkg::REG_START_IMAG:     start_im_reg <= cfg_data[W-1:0];
                efi_pkg::REG_KNEE_COUNT:     knee_reg     <= cfg_data[ITER_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    state_t                 state_reg, state_next;
    logic signed [W-1:0]    zr_reg, zr_next;
    logic signed [W-1:0]    zi_reg, zi_next;
    logic signed [W-1:0]    sr_reg, sr_next;
    logic signed [W-1:0]    si_reg, si_next;
    logic signed [W-1:0]    cr_reg, cr_next;
    logic signed [W-1:0]    ci_reg, ci_next;
    logic [PW-1:0]          rr_reg, rr_next;
    logic [PW-1:0]          ii_reg, ii_next;
    logic [ITER_WIDTH-1:0]  n_reg, n_next;
    logic [QW-1:0]          res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic [QW-1:0]          intensity_reg, intensity_next;

    // Shared multiplier.
    logic signed [W-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]   prod;

    always_comb
    begin
        case (state_reg)
            S_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    efi_mul #(
        .WIDTH (W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Intensity divider: 255*n / (knee + n).
    logic                   div_start;
    logic                   div_done;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic [QW-1:0]          div_quot;

    assign div_num = (NUM_W'(n_reg) << 8) - NUM_W'(n_reg);
    assign div_den = DEN_W'(knee_reg) + DEN_W'(n_reg);

    efi_div #(
        .NUM_WIDTH (NUM_W),
        .DEN_WIDTH (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Escape, cycle and limit tests on the current z.
    logic [PW-1:0]  mag;
    logic           escaped;
    logic           repeated;
    logic           save_point;
    logic           at_limit;
    logic           finish;
    logic           finish_zero;

    assign mag        = rr_reg + prod;
    assign escaped    = (n_reg != '0) && (mag > LIMIT);
    assign repeated   = (n_reg != '0) && (zr_reg == sr_reg) && (zi_reg == si_reg);
    assign save_point = (n_reg != '0) && ((n_reg & (n_reg + 1'b1)) == '0);
    assign at_limit   = n_reg >= max_iter_reg;

    // Next z from the squares and the cross product.
    logic [PW:0]     diff;
    logic [SW-1:0]   re_sum;
    logic [SW-1:0]   im_sum;

    assign diff   = {rr_reg[PW-1], rr_reg} - {ii_reg[PW-1], ii_reg};
    assign re_sum = {diff[PW], diff[PW:FRAC]} + {{(SW-W){cr_reg[W-1]}}, cr_reg};
    assign im_sum = {prod[PW-1], prod[PW-1:FRAC-1]} + {{(SW-W){ci_reg[W-1]}}, ci_reg};

    always_comb
    begin
        state_next     = state_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        sr_next        = sr_reg;
        si_next        = si_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        rr_next        = rr_reg;
        ii_next        = ii_reg;
        n_next         = n_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        intensity_next = intensity_reg;
        div_start      = 1'b0;
        finish         = 1'b0;
        finish_zero    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cr_next    = c_real;
                    ci_next    = c_imag;
                    zr_next    = start_re_reg;
                    zi_next    = start_im_reg;
                    sr_next    = start_re_reg;
                    si_next    = start_im_reg;
                    n_next     = '0;
                    state_next = S_RR;
                end
            end
            S_RR:
            begin
                state_next = S_II;
            end
            S_II:
            begin
                rr_next    = prod;
                state_next = S_RI;
            end
            S_RI:
            begin
                ii_next = prod;
                if (escaped)
                begin
                    finish = 1'b1;
                end
                else if (repeated)
                begin
                    finish      = 1'b1;
                    finish_zero = 1'b1;
                end
                else
                begin
                    if (save_point)
                    begin
                        sr_next = zr_reg;
                        si_next = zi_reg;
                    end
                    if (at_limit)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
                // A zero count or a found cycle gives zero without a division.
                if (finish)
                begin
                    if (finish_zero || n_reg == '0)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_UPD:
            begin
                zr_next    = saturate(re_sum);
                zi_next    = saturate(im_sum);
                n_next     = n_reg + 1'b1;
                state_next = S_RR;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    intensity_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        sr_reg        <= sr_next;
        si_reg        <= si_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        rr_reg        <= rr_next;
        ii_reg        <= ii_next;
        n_reg         <= n_next;
        res_reg       <= res_next;
        intensity_reg <= intensity_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign intensity = intensity_reg;

endmodule

// ===== rtl/efi_mul.sv =====
// Shared signed multiplier with a registered full-width product.
// Depends on nothing; used by the top-level sequencer for all squarings.
module efi_mul #(
    parameter int WIDTH = 32
) (
    input  logic                        clk,
    input  logic signed [WIDTH-1:0]     a,
    input  logic signed [WIDTH-1:0]     b,
    output logic signed [2*WIDTH-1:0]   prod
);

    logic signed [2*WIDTH-1:0] prod_reg;

    // One exact product per cycle, available on the next cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/efi_div.sv =====
// Restoring divider for the intensity, one quotient bit per cycle.
// Depends on efi_pkg for the quotient width.
module efi_div #(
    parameter int NUM_WIDTH = 24,
    parameter int DEN_WIDTH = 17
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [NUM_WIDTH-1:0]                 num,
    input  logic [DEN_WIDTH-1:0]                 den,
    output logic                                 done,
    output logic [efi_pkg::INTENSITY_WIDTH-1:0]  quot
);

    localparam int QW    = efi_pkg::INTENSITY_WIDTH;
    localparam int CW    = $clog2(QW);
    localparam int CMP_W = NUM_WIDTH + 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [DEN_WIDTH-1:0] den_reg, den_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [CMP_W-1:0]  shifted;
    logic              fits;

    // Trial subtraction of the divisor shifted to the current quotient bit.
    assign shifted = CMP_W'(den_reg) << cnt_reg;
    assign fits    = CMP_W'(rem_reg) >= shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW - 1);
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - shifted[NUM_WIDTH-1:0];
            end
            q_next[cnt_reg] = fits;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== tb/sv/escape_time_fractal_iterator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for escape_time_fractal_iterator: random and directed points
// with predicted intensities. Depends on efi_pkg and the RTL of the block only.
module escape_time_fractal_iterator_tb;

    localparam int COORD_W = 32;
    localparam int ITER_W = 16;
    localparam int CFG_W = (COORD_W > ITER_W) ? COORD_W : ITER_W;
    localparam int FRAC = COORD_W - 4;
    localparam int CFG_INDEX_W = efi_pkg::CFG_INDEX_WIDTH;
    localparam int CFG_INDEX_COUNT = 1 << CFG_INDEX_W;
    localparam int RANDOM_PHASES = 11;
    localparam int POINTS_PER_PHASE = 150;

    // Fixed-point constants for Q4.28 coordinates.
    localparam int Q_ONE = 1 << FRAC;
    localparam int COORD_TOP = 32'sh7FFF_FFFF;
    localparam int COORD_BOTTOM = 32'sh8000_0000;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam wide_t COORD_MAX = (wide_t'(1) <<< (COORD_W - 1)) - 1;
    localparam wide_t COORD_MIN = -(wide_t'(1) <<< (COORD_W - 1));
    localparam wide_t ESCAPE_RADIUS_SQ = wide_t'(1) <<< (2 * FRAC + 2);

    // Holds a copy of the configuration, predicts the intensity of each accepted
    // point and compares the arriving intensities in order.
    class intensity_tracker;
        logic [ITER_W-1:0] max_iter = 16'd256;
        coord_t start_re = '0;
        coord_t start_im = '0;
        logic [ITER_W-1:0] knee = 16'd16;
        logic [7:0] pending_intensity[$];
        int unsigned failures = 0;
        int unsigned points_noted = 0;
        int unsigned intensities_checked = 0;

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                efi_pkg::REG_MAX_ITERATIONS: max_iter = data[ITER_W-1:0];
                efi_pkg::REG_START_REAL: start_re = data[COORD_W-1:0];
                efi_pkg::REG_START_IMAG: start_im = data[COORD_W-1:0];
                efi_pkg::REG_KNEE_COUNT: knee = data[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function coord_t clamp_coord(wide_t v);
            if (v > COORD_MAX)
                return COORD_MAX[COORD_W-1:0];
            if (v < COORD_MIN)
                return COORD_MIN[COORD_W-1:0];
            return v[COORD_W-1:0];
        endfunction

        // Iterates z = z*z + c with saturation, an exact escape test and a
        // saved copy of z refreshed at power-of-two intervals.
        function logic [7:0] escape_intensity(coord_t cr, coord_t ci);
            coord_t zr;
            coord_t zi;
            coord_t saved_re;
            coord_t saved_im;
            wide_t sq_re;
            wide_t sq_im;
            wide_t sq_cross;
            longint unsigned n;
            longint unsigned since;
            longint unsigned span;
            zr = start_re;
            zi = start_im;
            saved_re = zr;
            saved_im = zi;
            n = 0;
            since = 0;
            span = 1;
            while (n < max_iter) begin
                sq_re = wide_t'(zr) * wide_t'(zr);
                sq_im = wide_t'(zi) * wide_t'(zi);
                sq_cross = wide_t'(zr) * wide_t'(zi);
                zr = clamp_coord(((sq_re - sq_im) >>> FRAC) + wide_t'(cr));
                zi = clamp_coord((sq_cross >>> (FRAC - 1)) + wide_t'(ci));
                n++;
                if (wide_t'(zr) * wide_t'(zr) + wide_t'(zi) * wide_t'(zi) > ESCAPE_RADIUS_SQ)
                    break;
                // An exact repeat of the saved z means the orbit is periodic.
                if (zr == saved_re && zi == saved_im)
                    return 8'd0;
                since++;
                if (since == span) begin
                    span = span << 1;
                    since = 0;
                    saved_re = zr;
                    saved_im = zi;
                end
            end
            if (n == 0)
                return 8'd0;
            return 8'((255 * n) / (knee + n));
        endfunction

        function void note_point(coord_t cr, coord_t ci);
            pending_intensity.push_back(escape_intensity(cr, ci));
            points_noted++;
        endfunction

        function void check_intensity(logic [7:0] actual);
            logic [7:0] expected;
            if (pending_intensity.size() == 0) begin
                $display("%0t: intensity %0d arrived with no point outstanding", $time, actual);
                failures++;
                return;
            end
            expected = pending_intensity.pop_front();
            intensities_checked++;
            if (actual !== expected) begin
                $display("%0t: intensity mismatch, expected %0d, actual %0d",
                         $time, expected, actual);
                failures++;
            end
        endfunction

        // Longest quiet stretch a correct block can show with this limit.
        function int unsigned beat_timeout();
            return 4 * (4 * max_iter + 64) + 2000;
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    coord_t c_real = '0;
    coord_t c_imag = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [efi_pkg::INTENSITY_WIDTH-1:0] intensity;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    intensity_tracker tracker;
    bit send_gaps_on = 1'b1;
    bit recv_stalls_on = 1'b1;
    int unsigned idle_cycles = 0;
    int unsigned settings_applied = 0;

    escape_time_fractal_iterator #(
        .COORD_WIDTH(COORD_W),
        .ITER_WIDTH(ITER_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .c_real(c_real),
        .c_imag(c_imag),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .intensity(intensity),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Beat monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                tracker.note_point(c_real, c_imag);
            if (out_valid && out_ready)
                tracker.check_intensity(intensity);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= tracker.beat_timeout()) begin
                $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                $display("escape_time_fractal_iterator: mismatch");
                $finish;
            end
        end
    end

    // Receiver: while recv_stalls_on, stalls a random number of cycles before each intensity beat.
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = recv_stalls_on ? $urandom_range(0, 19) : 0;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic int pick_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int special_coord(int unsigned which);
        case (which)
            0: return 0;
            1: return -Q_ONE;
            2: return Q_ONE;
            3: return 2 * Q_ONE;
            4: return -2 * Q_ONE;
            5: return COORD_TOP;
            6: return COORD_BOTTOM;
            default: return Q_ONE / 4;
        endcase
    endfunction

    // Mostly points around the set, some on a coarse grid so that orbits repeat
    // exactly, some with every bit random and a few special values.
    function automatic void random_point(output coord_t cr, output coord_t ci);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            cr = pick_between(-2 * Q_ONE, Q_ONE / 2);
            ci = pick_between(-5 * Q_ONE / 4, 5 * Q_ONE / 4);
        end else if (pick < 75) begin
            cr = pick_between(-512, 128) <<< (FRAC - 8);
            ci = pick_between(-320, 320) <<< (FRAC - 8);
        end else if (pick < 90) begin
            cr = $urandom;
            ci = $urandom;
        end else begin
            cr = special_coord($urandom_range(0, 7));
            ci = special_coord($urandom_range(0, 7));
        end
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_register(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] limit_data, input coord_t sr,
                                  input coord_t si, input logic [CFG_W-1:0] knee_data);
        write_register(efi_pkg::REG_MAX_ITERATIONS, limit_data);
        write_register(efi_pkg::REG_START_REAL, sr);
        write_register(efi_pkg::REG_START_IMAG, si);
        write_register(efi_pkg::REG_KNEE_COUNT, knee_data);
        settings_applied++;
    endtask

    // Sends one point; valid stays high across back-to-back beats.
    task automatic send_point(input coord_t cr, input coord_t ci);
        int unsigned gap;
        gap = send_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        c_real <= cr;
        c_imag <= ci;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drops valid after the last beat and waits for every intensity to arrive.
    task automatic finish_phase();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending_intensity.size() != 0);
    endtask

    initial
    begin
        int unsigned limit;
        int unsigned pick;
        int unsigned settle;
        coord_t sr;
        coord_t si;
        coord_t cr;
        coord_t ci;
        logic [ITER_W-1:0] knee_value;

        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: cycles found at once, escapes, saturation.
        settings_applied++;
        send_point(0, 0);
        send_point(-Q_ONE, 0);
        send_point(-2 * Q_ONE, 0);
        send_point(2 * Q_ONE, 0);
        send_point(Q_ONE / 2, 0);
        send_point(-3 * Q_ONE / 4, Q_ONE / 10);
        send_point(3 * Q_ONE / 10, Q_ONE / 2);
        send_point(COORD_TOP, COORD_TOP);
        send_point(COORD_BOTTOM, COORD_BOTTOM);
        send_point(COORD_TOP, COORD_BOTTOM);
        send_point(COORD_BOTTOM, COORD_TOP);
        send_point(0, -Q_ONE);
        finish_phase();

        // Zero iteration limit, written with junk in the upper bits.
        apply_settings(32'hABCD_0000, 0, 0, 32'h0000_0010);
        send_point(0, 0);
        send_point(COORD_TOP, COORD_BOTTOM);
        send_point(-Q_ONE / 2, Q_ONE / 4);
        finish_phase();

        // Largest limit with a zero knee; only points that settle quickly.
        apply_settings(32'h1234_FFFF, 0, 0, 32'h5A5A_0000);
        send_point(0, 0);
        send_point(-Q_ONE, 0);
        send_point(3 * Q_ONE, 0);
        send_point(Q_ONE / 100 * 26, 0);
        send_point(COORD_BOTTOM, COORD_BOTTOM);
        finish_phase();

        // Extreme start values and the largest knee.
        apply_settings(100, COORD_BOTTOM, COORD_TOP, 32'hFFFF_FFFF);
        send_point(0, 0);
        send_point(-Q_ONE, Q_ONE);
        send_point(COORD_TOP, 0);
        finish_phase();

        // Writes to unused indexes must leave the registers alone.
        apply_settings(100, 0, 0, 16);
        for (int idx = efi_pkg::REG_KNEE_COUNT + 1; idx < CFG_INDEX_COUNT; idx++)
            write_register(CFG_INDEX_W'(idx), $urandom);
        send_point(-Q_ONE / 2, 0);
        send_point(0, Q_ONE);
        finish_phase();

        // Random phases, each with its own limit, start, knee and idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: limit = 256;
                1: limit = 1;
                2: limit = 2;
                3: limit = 5;
                4: limit = 12;
                5: limit = 30;
                6: limit = 64;
                7: limit = 128;
                8: limit = $urandom_range(0, 300);
                9: limit = $urandom_range(1, 40);
                default: limit = 20;
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                sr = 0;
                si = 0;
            end else if (pick < 9) begin
                sr = pick_between(-Q_ONE / 2, Q_ONE / 2);
                si = pick_between(-Q_ONE / 2, Q_ONE / 2);
            end else begin
                sr = $urandom;
                si = $urandom;
            end
            case ($urandom_range(0, 5))
                0: knee_value = 0;
                1: knee_value = 1;
                2: knee_value = 16;
                3: knee_value = ITER_W'($urandom_range(0, 255));
                4: knee_value = 16'hFFFF;
                default: knee_value = ITER_W'($urandom_range(0, 65535));
            endcase
            apply_settings({16'($urandom), ITER_W'(limit)}, sr, si,
                           {16'($urandom), knee_value});
            send_gaps_on = (phase == 0) || (phase != 2 && $urandom_range(0, 3) != 0);
            recv_stalls_on = (phase == 0) || (phase != 2 && $urandom_range(0, 3) != 0);
            for (int k = 0; k < POINTS_PER_PHASE; k++) begin
                random_point(cr, ci);
                send_point(cr, ci);
            end
            finish_phase();
        end

        // Give a stray beat time to show up before the verdict.
        settle = 4 * tracker.max_iter + 20;
        if (settle > 2000)
            settle = 2000;
        repeat (settle) @(posedge clk);

        tracker.failures += tracker.pending_intensity.size();
        $display("Checked %0d intensities for %0d points under %0d register settings.",
                 tracker.intensities_checked, tracker.points_noted, settings_applied);
        $display("Limits from 0 to 65535, knees from 0 to 65535, extreme starts, %0d failures.",
                 tracker.failures);
        if (tracker.failures == 0)
            $display("escape_time_fractal_iterator: match");
        else
            $display("escape_time_fractal_iterator: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/efi_pkg.sv
rtl/efi_mul.sv
rtl/efi_div.sv
rtl/escape_time_fractal_iterator.sv
tb/sv/escape_time_fractal_iterator_tb.sv
